// ===== design/assert_macros.svh =====
// Assertion macros shared by the shear pass modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define LSLI_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lsli check failed");

// Condition in one cycle implies expression in the next.
`define LSLI_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lsli next-cycle check failed");

`endif

// ===== design/lsli_pkg.sv =====
// Types and constants of the line shear pass.
package lsli_pkg;

   localparam logic [1:0] CSR_SHEAR_FACTOR = 2'd0;
   localparam logic [1:0] CSR_LINE_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_LINE_COUNT   = 2'd2;

   localparam int CSR_DATA_W  = 18;
   localparam int DX_MIN      = -4096;
   localparam int DX_MAX      = 4095;
   localparam int COUNT_CAP   = 4096;

   typedef struct packed {
      logic [11:0] dest_pos;
      logic [11:0] line_number;
      logic [31:0] out_pixel;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

// ===== design/lsli_line_shift.sv =====
// Per-line shift: shear factor times distance from the center line, split into dx and fraction.
module lsli_line_shift (
   input  logic signed [17:0] shear_factor,
   input  logic        [11:0] line_index,
   input  logic        [12:0] line_count,
   output logic signed [12:0] shift_dx,
   output logic        [15:0] shift_frac
);

   logic        [11:0] half_w;
   logic signed [13:0] dist_w;
   logic signed [31:0] prod_w;
   logic signed [15:0] whole_w;

   always_comb begin
      half_w  = line_count[12:1];
      dist_w  = $signed({2'b00, line_index}) - $signed({2'b00, half_w});
      prod_w  = shear_factor * dist_w;
      shift_frac = prod_w[15:0];
      // upper half is floor(p / 65536) since the low part is the fraction
      whole_w = prod_w[31:16];
      if (whole_w < 16'(lsli_pkg::DX_MIN)) begin
         shift_dx = 13'(lsli_pkg::DX_MIN);
      end else if (whole_w > 16'(lsli_pkg::DX_MAX)) begin
         shift_dx = 13'(lsli_pkg::DX_MAX);
      end else begin
         shift_dx = whole_w[12:0];
      end
   end

endmodule

// ===== design/lsli_blend.sv =====
// Alpha-aware linear blend of two neighboring ARGB pixels.
module lsli_blend (
   input  logic [31:0] left_pixel,
   input  logic [31:0] right_pixel,
   input  logic [15:0] frac,
   output logic [31:0] blend_pixel
);

   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [15:0] f);
      logic [16:0] wl;
      logic [24:0] sum;
      wl  = 17'h10000 - {1'b0, f};
      sum = 25'(a) * 25'(wl) + 25'(b) * 25'(f);
      return sum[23:16];
   endfunction

   logic left_clear_w;
   logic right_clear_w;

   always_comb begin
      left_clear_w  = left_pixel[31:24] == 8'h00;
      right_clear_w = right_pixel[31:24] == 8'h00;
      if (left_clear_w && right_clear_w) begin
         blend_pixel = 32'h0000_0000;
      end else if (left_clear_w) begin
         blend_pixel = right_pixel;
      end else if (right_clear_w) begin
         blend_pixel = left_pixel;
      end else begin
         blend_pixel = {8'hFF,
                        mix(left_pixel[23:16], right_pixel[23:16], frac),
                        mix(left_pixel[15:8],  right_pixel[15:8],  frac),
                        mix(left_pixel[7:0],   right_pixel[7:0],   frac)};
      end
   end

endmodule

// ===== design/lsli_rsp_queue.sv =====
// Two-entry result queue; takes up to two results per beat and hands one out per cycle while rsp_ready is high.
`include "assert_macros.svh"
module lsli_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  lsli_pkg::push_type    push,
   output logic [1:0]            room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lsli_pkg::rsp_item_type head
);

   lsli_pkg::rsp_item_type q_ff [2];
   lsli_pkg::rsp_item_type q_in [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic [1:0] keep_w;
   logic       pop_w;

   always_comb begin
      pop_w  = rsp_valid && rsp_ready;
      keep_w = count_ff - {1'b0, pop_w};
      room   = 2'd2 - keep_w;
      q_in[0] = (keep_w != 2'd0) ? (pop_w ? q_ff[1] : q_ff[0]) : push.item0;
      if (keep_w == 2'd2) begin
         q_in[1] = q_ff[1];
      end else if (keep_w == 2'd1) begin
         q_in[1] = push.item0;
      end else begin
         q_in[1] = push.item1;
      end
      count_in = keep_w + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid = count_ff != 2'd0;
   assign head      = q_ff[0];

   `LSLI_CHECK(a_count_bound, count_ff <= 2'd2)
   `LSLI_CHECK(a_push_fits, push.count <= room)

endmodule

// ===== design/line_shear_linear_interp_core.sv =====
// Top level of the line shear pass with linear interpolation.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_in_pixel
//  rsp     | out       | rsp_valid / rsp_ready  | dest_pos, line_number, out_pixel, last
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// One pixel per clock while rsp is not stalled: input register, combinational blend/shift logic, result queue.
// A req beat is registered in the input register, and its results in the queue before rsp shows them.
// The last pixel of a line gives up to two results; the queue absorbs the extra one because the
// first pixel of the next line gives none, so only rsp stalls ever hold a req beat.
// rsp stalls back up through the two-entry queue into the input register and req_ready.
// Synchronous reset clears line state and loads register defaults; csr_ready is always high.
`include "assert_macros.svh"
module line_shear_linear_interp_core #(
   parameter int MAX_LINE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_in_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_dest_pos,
   output logic [11:0] rsp_line_number,
   output logic [31:0] rsp_out_pixel,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [lsli_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int LEN_CAP = (MAX_LINE < 4096) ? MAX_LINE : 4096;

   logic signed [17:0] shear_ff;
   logic        [12:0] length_ff;
   logic        [12:0] count_cfg_ff;

   logic        in_valid_ff;
   logic [31:0] in_pixel_ff;

   logic [31:0]        prev_pixel_ff;
   logic [11:0]        position_ff;
   logic [11:0]        line_index_ff;
   logic signed [12:0] line_shift_ff;
   logic [15:0]        line_frac_ff;

   logic [12:0]        len_w;
   logic [12:0]        cnt_w;
   logic signed [12:0] new_dx_w;
   logic [15:0]        new_frac_w;
   logic [31:0]        blend_w;
   logic signed [14:0] dx_ext_w;
   logic signed [14:0] pos1_w;
   logic signed [14:0] pos2_w;
   logic               start_w;
   logic               end_w;
   logic               emit1_w;
   logic               emit2_w;
   logic [11:0]        next_index_w;
   logic [1:0]         room_w;
   logic               fire_w;
   lsli_pkg::push_type     push_w;
   lsli_pkg::rsp_item_type res1_w;
   lsli_pkg::rsp_item_type res2_w;
   lsli_pkg::rsp_item_type head_w;

   always_comb begin
      len_w = length_ff;
      if (len_w < 13'd2) len_w = 13'd2;
      if (len_w > 13'(LEN_CAP)) len_w = 13'(LEN_CAP);
      cnt_w = count_cfg_ff;
      if (cnt_w < 13'd1) cnt_w = 13'd1;
      if (cnt_w > 13'(lsli_pkg::COUNT_CAP)) cnt_w = 13'(lsli_pkg::COUNT_CAP);
   end

   lsli_line_shift u_shift (
      .shear_factor (shear_ff),
      .line_index   (line_index_ff),
      .line_count   (cnt_w),
      .shift_dx     (new_dx_w),
      .shift_frac   (new_frac_w)
   );

   lsli_blend u_blend (
      .left_pixel  (prev_pixel_ff),
      .right_pixel (in_pixel_ff),
      .frac        (line_frac_ff),
      .blend_pixel (blend_w)
   );

   always_comb begin
      start_w  = position_ff == 12'd0;
      end_w    = {1'b0, position_ff} >= (len_w - 13'd1);
      dx_ext_w = {{2{line_shift_ff[12]}}, line_shift_ff};
      pos1_w   = $signed({3'b000, position_ff}) - 15'sd1 + dx_ext_w;
      pos2_w   = $signed({2'b00, len_w}) - 15'sd1 + dx_ext_w;
      emit1_w  = !start_w && (pos1_w >= 15'sd0) && (pos1_w < $signed({2'b00, len_w}));
      emit2_w  = !start_w && end_w && (pos2_w >= 15'sd0)
                 && (pos2_w < $signed({2'b00, len_w}));

      res1_w.dest_pos    = pos1_w[11:0];
      res1_w.line_number = line_index_ff;
      res1_w.out_pixel   = blend_w;
      res1_w.last        = !emit2_w;
      res2_w.dest_pos    = pos2_w[11:0];
      res2_w.line_number = line_index_ff;
      res2_w.out_pixel   = in_pixel_ff;
      res2_w.last        = 1'b1;

      push_w.count = {1'b0, emit1_w} + {1'b0, emit2_w};
      push_w.item0 = emit1_w ? res1_w : res2_w;
      push_w.item1 = res2_w;
      fire_w = in_valid_ff && (push_w.count <= room_w);
      if (!fire_w) push_w.count = 2'd0;

      next_index_w = line_index_ff + 12'd1;
      if ({1'b0, next_index_w} >= cnt_w) next_index_w = 12'd0;
   end

   assign req_ready = !in_valid_ff || fire_w;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shear_ff      <= 18'sd0;
         length_ff     <= 13'd4096;
         count_cfg_ff  <= 13'd4096;
         in_valid_ff   <= 1'b0;
         prev_pixel_ff <= 32'd0;
         position_ff   <= 12'd0;
         line_index_ff <= 12'd0;
         line_shift_ff <= 13'sd0;
         line_frac_ff  <= 16'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lsli_pkg::CSR_SHEAR_FACTOR: shear_ff     <= $signed(csr_data[17:0]);
               lsli_pkg::CSR_LINE_LENGTH:  length_ff    <= csr_data[12:0];
               lsli_pkg::CSR_LINE_COUNT:   count_cfg_ff <= csr_data[12:0];
               default: ;
            endcase
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire_w) begin
            prev_pixel_ff <= in_pixel_ff;
            if (start_w) begin
               line_shift_ff <= new_dx_w;
               line_frac_ff  <= new_frac_w;
               position_ff   <= 12'd1;
            end else if (end_w) begin
               position_ff   <= 12'd0;
               line_index_ff <= next_index_w;
            end else begin
               position_ff   <= position_ff + 12'd1;
            end
         end
      end
      if (req_valid && req_ready) begin
         in_pixel_ff <= req_in_pixel;
      end
   end

   lsli_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_w),
      .room      (room_w),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head_w)
   );

   assign rsp_dest_pos    = head_w.dest_pos;
   assign rsp_line_number = head_w.line_number;
   assign rsp_out_pixel   = head_w.out_pixel;
   assign rsp_last        = head_w.last;

   `LSLI_CHECK(a_first_pixel_silent, !(fire_w && start_w) || (push_w.count == 2'd0))
   `LSLI_NEXT(a_held_beat_stays, in_valid_ff && !fire_w, in_valid_ff && $stable(in_pixel_ff))
   `LSLI_CHECK(a_position_bound, position_ff <= 12'(LEN_CAP - 1))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for line_shear_linear_interp_core: random and directed pixel lines.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned RUN_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_FROM = 1400;
   localparam int REPORT_CAP = 60;

   // Shear pass predictor plus the queue of writes it expects from the block.
   class shear_pass_model;
      logic signed [17:0] shear;
      logic [12:0] length_reg;
      logic [12:0] count_reg;
      logic [31:0] prev_pix;
      logic [11:0] pos_idx;
      logic [11:0] line_idx;
      logic signed [12:0] shift;
      logic [15:0] frac;
      lsli_pkg::rsp_item_type expected_writes[$];
      int mismatches;

      function new();
         shear = '0;
         length_reg = 13'd4096;
         count_reg = 13'd4096;
         prev_pix = '0;
         pos_idx = '0;
         line_idx = '0;
         shift = '0;
         frac = '0;
         mismatches = 0;
      endfunction

      task report(string msg);
         if (mismatches < REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void set_register(logic [1:0] idx, logic [lsli_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            lsli_pkg::CSR_SHEAR_FACTOR: shear = data;
            lsli_pkg::CSR_LINE_LENGTH: length_reg = data[12:0];
            lsli_pkg::CSR_LINE_COUNT: count_reg = data[12:0];
            default: ;
         endcase
      endfunction

      function int line_len();
         int l;
         l = length_reg;
         if (l < 2) l = 2;
         if (l > 4096) l = 4096;
         return l;
      endfunction

      function int lines_total();
         int c;
         c = count_reg;
         if (c < 1) c = 1;
         if (c > 4096) c = 4096;
         return c;
      endfunction

      function logic [7:0] mix(logic [7:0] a, logic [7:0] b, logic [15:0] f);
         int unsigned t;
         t = a * (32'd65536 - f) + b * f;
         return t[23:16];
      endfunction

      function logic [31:0] blend(logic [31:0] left, logic [31:0] right, logic [15:0] f);
         if (left[31:24] == 8'h00 && right[31:24] == 8'h00) return 32'h0;
         if (left[31:24] == 8'h00) return right;
         if (right[31:24] == 8'h00) return left;
         return {8'hFF, mix(left[23:16], right[23:16], f), mix(left[15:8], right[15:8], f),
                 mix(left[7:0], right[7:0], f)};
      endfunction

      // Shift of the new line: floor and fraction of shear * (line - center), dx saturated.
      function void start_line();
         longint lam;
         longint d;
         longint p;
         longint dx;
         lam = shear;
         d = longint'(line_idx) - longint'(lines_total() / 2);
         p = lam * d;
         frac = p[15:0];
         dx = p >>> 16;
         if (dx < lsli_pkg::DX_MIN) dx = lsli_pkg::DX_MIN;
         if (dx > lsli_pkg::DX_MAX) dx = lsli_pkg::DX_MAX;
         shift = dx[12:0];
      endfunction

      function void add_write(ref lsli_pkg::rsp_item_type fresh[$], input int p,
                              input logic [31:0] pix, input int len);
         lsli_pkg::rsp_item_type w;
         if (p < 0 || p >= len) return;
         w.dest_pos = p[11:0];
         w.line_number = line_idx;
         w.out_pixel = pix;
         w.last = 1'b0;
         fresh.push_back(w);
      endfunction

      function void accept_pixel(logic [31:0] pix);
         lsli_pkg::rsp_item_type fresh[$];
         int len;
         int x;
         int sx;
         len = line_len();
         x = pos_idx;
         if (x == 0) begin
            start_line();
            prev_pix = pix;
            pos_idx = 12'd1;
            return;
         end
         sx = shift;
         add_write(fresh, x - 1 + sx, blend(prev_pix, pix, frac), len);
         prev_pix = pix;
         if (x >= len - 1) begin
            add_write(fresh, len - 1 + sx, pix, len);
            pos_idx = '0;
            line_idx = line_idx + 12'd1;
            if (int'(line_idx) >= lines_total()) line_idx = '0;
         end else begin
            pos_idx = 12'(x + 1);
         end
         if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) expected_writes.push_back(fresh[i]);
      endfunction

      task check_write(lsli_pkg::rsp_item_type got);
         lsli_pkg::rsp_item_type want;
         if (expected_writes.size() == 0) begin
            report($sformatf("unexpected beat pos %0d line %0d pixel %08h",
                             got.dest_pos, got.line_number, got.out_pixel));
            return;
         end
         want = expected_writes.pop_front();
         if (got.dest_pos !== want.dest_pos)
            report($sformatf("dest_pos got %0d want %0d", got.dest_pos, want.dest_pos));
         if (got.line_number !== want.line_number)
            report($sformatf("line_number got %0d want %0d", got.line_number,
                             want.line_number));
         if (got.out_pixel !== want.out_pixel)
            report($sformatf("out_pixel got %08h want %08h at pos %0d", got.out_pixel,
                             want.out_pixel, want.dest_pos));
         if (got.last !== want.last)
            report($sformatf("last got %0b want %0b at pos %0d", got.last, want.last,
                             want.dest_pos));
      endtask

      function int pending();
         return expected_writes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [31:0] req_in_pixel;
   logic rsp_valid;
   logic rsp_ready;
   logic [11:0] rsp_dest_pos;
   logic [11:0] rsp_line_number;
   logic [31:0] rsp_out_pixel;
   logic rsp_last;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [lsli_pkg::CSR_DATA_W-1:0] csr_data;

   shear_pass_model model = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int stall_left = 0;
   int unsigned cycle_count = 0;
   int rate_choice[3] = '{0, 12, 40};

   line_shear_linear_interp_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_pixel(req_in_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_dest_pos(rsp_dest_pos),
      .rsp_line_number(rsp_line_number),
      .rsp_out_pixel(rsp_out_pixel),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Receiver side: random stall bursts on rsp_ready.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(1, 12) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin : watch
      lsli_pkg::rsp_item_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) model.set_register(csr_index, csr_data);
         if (req_valid && req_ready) model.accept_pixel(req_in_pixel);
         if (rsp_valid && rsp_ready) begin
            got.dest_pos = rsp_dest_pos;
            got.line_number = rsp_line_number;
            got.out_pixel = rsp_out_pixel;
            got.last = rsp_last;
            model.check_write(got);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_shear_linear_interp_core verification failed");
      $finish;
   end

   // Valid is left high after the beat; callers drop it when the burst ends.
   task send_pixel(logic [31:0] pix);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_in_pixel = pix;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [lsli_pkg::CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Wait for every expected beat, then let a pixel that gives none drain through.
   task settle();
      req_valid = 1'b0;
      csr_valid = 1'b0;
      while (model.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_pixel();
      logic [7:0] alpha;
      case ($urandom_range(0, 4))
         0: alpha = 8'h00;
         1: alpha = 8'hFF;
         default: alpha = 8'($urandom());
      endcase
      return {alpha, 24'($urandom())};
   endfunction

   function automatic logic [lsli_pkg::CSR_DATA_W-1:0] pick_shear();
      case ($urandom_range(0, 7))
         0: return 18'h20000;
         1: return 18'h1FFFF;
         2: return 18'h10000;
         3: return 18'h30000;
         4: return 18'h00000;
         5: return 18'($urandom());
         default: return 18'($urandom_range(0, 131072) - 65536);
      endcase
   endfunction

   function automatic logic [lsli_pkg::CSR_DATA_W-1:0] pick_length();
      logic [12:0] len;
      case ($urandom_range(0, 9))
         0: len = 13'($urandom_range(0, 1));
         1: len = 13'($urandom_range(4097, 8191));
         2: len = 13'd4096;
         3: len = 13'($urandom_range(17, 300));
         default: len = 13'($urandom_range(2, 16));
      endcase
      return {5'($urandom()), len};
   endfunction

   function automatic logic [lsli_pkg::CSR_DATA_W-1:0] pick_count();
      logic [12:0] cnt;
      case ($urandom_range(0, 7))
         0: cnt = 13'd0;
         1: cnt = 13'($urandom_range(4097, 8191));
         2: cnt = 13'd4096;
         3: cnt = 13'($urandom_range(9, 4096));
         default: cnt = 13'($urandom_range(1, 8));
      endcase
      return {5'($urandom()), cnt};
   endfunction

   initial begin : stimulus
      int random_sent;
      int burst;
      int waited;
      logic [31:0] opening[12];
      opening = '{32'h00FFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h7F000000,
                  32'h00123456, 32'h00ABCDEF, 32'h80FF00FF, 32'h00000000,
                  32'h01010101, 32'hFEFEFEFE, 32'hFFFFFFFF, 32'hFF000000};
      random_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_pixel = '0;
      rsp_ready = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Three short lines: transparent pairs, one-sided alpha, opaque mixes.
      stall_pct = 12;
      write_reg(CSR_UNUSED, 18'h3FFFF);
      write_reg(lsli_pkg::CSR_SHEAR_FACTOR, 18'h0A000);
      write_reg(lsli_pkg::CSR_LINE_LENGTH, 18'd4);
      write_reg(lsli_pkg::CSR_LINE_COUNT, 18'd3);
      csr_valid = 1'b0;
      foreach (opening[i]) send_pixel(opening[i]);
      settle();

      // Shift saturates high; only one write lands at the last position.
      write_reg(lsli_pkg::CSR_SHEAR_FACTOR, 18'h20000);
      write_reg(lsli_pkg::CSR_LINE_LENGTH, 18'd8191);
      write_reg(lsli_pkg::CSR_LINE_COUNT, 18'd8191);
      csr_valid = 1'b0;
      send_pixel(32'hFF8040C0);
      send_pixel(32'hC0102030);
      settle();
      // Shorten the line mid-way: next pixel ends it, every write dropped.
      write_reg(lsli_pkg::CSR_LINE_LENGTH, 18'd1);
      csr_valid = 1'b0;
      send_pixel(32'h55AA55AA);
      settle();
      write_reg(lsli_pkg::CSR_SHEAR_FACTOR, 18'h1FFFF);
      write_reg(lsli_pkg::CSR_LINE_LENGTH, 18'h3E002);
      csr_valid = 1'b0;
      send_pixel(32'hAA55AA55);
      send_pixel(32'h3C3C3C3C);
      settle();

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         if (random_sent >= QUIET_FROM) begin
            gap_pct = 0;
            stall_pct = 0;
            stall_left = 0;
         end else begin
            gap_pct = rate_choice[$urandom_range(0, 2)];
            stall_pct = rate_choice[$urandom_range(0, 2)];
         end
         write_reg(lsli_pkg::CSR_SHEAR_FACTOR, pick_shear());
         write_reg(lsli_pkg::CSR_LINE_LENGTH, pick_length());
         write_reg(lsli_pkg::CSR_LINE_COUNT, pick_count());
         csr_valid = 1'b0;
         burst = $urandom_range(20, 80);
         repeat (burst) begin
            send_pixel(pick_pixel());
            random_sent++;
         end
         req_valid = 1'b0;
      end

      waited = 0;
      while (model.pending() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (model.pending() != 0)
         model.report($sformatf("%0d expected beats never arrived", model.pending()));
      if (model.mismatches == 0)
         $display("line_shear_linear_interp_core verification clean");
      else
         $display("line_shear_linear_interp_core verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/lsli_pkg.sv
design/lsli_line_shift.sv
design/lsli_blend.sv
design/lsli_rsp_queue.sv
design/line_shear_linear_interp_core.sv
tb/sv/tb_top.sv
